// File: design/semb_pkg.sv
// Shared types and constants for the semaphore bank with wait queues.
// Holds the field widths of the request and response words and the operation codes.
// No dependencies.
`default_nettype none

package semb_pkg;

   localparam int MODE_W        = 3;
   localparam int SEM_INDEX_W   = 6;
   localparam int TASK_ID_W     = 8;
   localparam int INIT_VALUE_W  = 15;
   localparam int STATUS_W      = 3;
   localparam int COUNT_VALUE_W = 16;
   localparam int WOKEN_TASK_W  = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_OPEN  = 3'd0,
      MODE_WAIT  = 3'd1,
      MODE_POST  = 3'd2,
      MODE_READ  = 3'd3,
      MODE_CLOSE = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_BLOCKED  = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_NOT_OPEN = 3'd3,
      STAT_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic [SEM_INDEX_W-1:0]  sem_index;
      logic [TASK_ID_W-1:0]    task_id;
      logic [INIT_VALUE_W-1:0] init_value;
   } req_word_type;

endpackage

`default_nettype wire

// File: design/semb_ifs.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on semb_pkg for the field widths.
`default_nettype none

interface semb_req_if import semb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       mode;
   logic [SEM_INDEX_W-1:0]  sem_index;
   logic [TASK_ID_W-1:0]    task_id;
   logic [INIT_VALUE_W-1:0] init_value;

   modport source (output valid, mode, sem_index, task_id, init_value, input ready);
   modport sink   (input valid, mode, sem_index, task_id, init_value, output ready);
endinterface

interface semb_rsp_if import semb_pkg::*; ();
   logic                            valid;
   logic                            ready;
   logic [STATUS_W-1:0]             status;
   logic signed [COUNT_VALUE_W-1:0] count_value;
   logic                            woken_valid;
   logic [WOKEN_TASK_W-1:0]         woken_task;

   modport source (output valid, status, count_value, woken_valid, woken_task, input ready);
   modport sink   (input valid, status, count_value, woken_valid, woken_task, output ready);
endinterface

`default_nettype wire

// File: design/semb_slot_ram.sv
// Storage for the queued task ids of all semaphores.
// One write port and one read port with registered read data; no dependencies.
`default_nettype none

module semb_slot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/semaphore_bank_with_wait_queues.sv
// Top level of the semaphore bank: per-semaphore state memory, wait-queue slots, result register.
// Depends on semb_pkg, semb_req_if, semb_rsp_if and semb_slot_ram.
//
//   Channel   Dir  Handshake      Word
//   req_chan  in   valid/ready    mode, sem_index, task_id, init_value
//   rsp_chan  out  valid/ready    status, count_value, woken_valid, woken_task
//
// One word is accepted per cycle while the result side is not stalled; its result is
// computed in the operation stage and presented from the result register. The rate is set by
// the read-modify-write of the semaphore state memory, which a one-entry forward from the write
// port keeps at one word per cycle. Reset clears the entry valid bits, so no clearing pass
// is needed. A stalled result keeps its word in the result register, one more word waits in the
// operation stage, and then the input side stalls until the result is taken.
`default_nettype none

module semaphore_bank_with_wait_queues import semb_pkg::*; #(
   parameter int NUM_SEMS     = 64,
   parameter int QUEUE_DEPTH  = 16,
   parameter int TASK_ID_BITS = 8,
   parameter int COUNT_BITS   = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   semb_req_if.sink   req_chan,
   semb_rsp_if.source rsp_chan
);

   localparam int SIDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int QB     = $clog2(QUEUE_DEPTH);
   localparam int SLOTS  = NUM_SEMS * QUEUE_DEPTH;
   localparam int SAW    = $clog2(SLOTS);
   localparam int CB     = COUNT_BITS;
   localparam int TW     = TASK_ID_BITS;

   localparam logic [QB-1:0] TAIL_RST = QB'(QUEUE_DEPTH - 1);
   localparam logic [CB-1:0] CNT_MAX  = {1'b0, {(CB-1){1'b1}}};
   localparam logic [CB-1:0] CNT_MIN  = {1'b1, {(CB-1){1'b0}}};

   typedef struct packed {
      logic          open;
      logic [CB-1:0] count;
      logic [QB-1:0] head;
      logic [QB-1:0] tail;
   } sem_state_type;

   localparam sem_state_type ST_RST = '{open: 1'b0, count: '0, head: '0, tail: TAIL_RST};

   function automatic logic [QB-1:0] next_ptr(input logic [QB-1:0] p);
      next_ptr = (p == TAIL_RST) ? '0 : QB'(p + 1'b1);
   endfunction

   // State memory and its valid bits.
   sem_state_type state_mem [NUM_SEMS];
   logic [NUM_SEMS-1:0] sem_vld_ff;

   // Operation stage.
   logic          b_vld_ff, b_vld_in;
   req_word_type  b_ff;
   sem_state_type st_rd_ff;
   logic          st_vld_ff;
   sem_state_type fwd_ff;
   logic          fwd_hit_ff, fwd_hit_in;

   // Result stage.
   logic          rsp_vld_ff, rsp_vld_in;
   status_type    status_ff, status_in;
   logic [CB-1:0] count_ff, count_in;
   logic          wv_ff, wv_in;

   logic req_fire, rsp_free, b_adv;

   logic [SIDX_W+SEM_INDEX_W-1:0] req_idx_ext, b_idx_ext;
   logic [SIDX_W-1:0]             req_idx, b_idx;
   logic                          b_in_range;

   sem_state_type st_cur, st_new;
   logic          st_we;
   logic [QB-1:0] tail_next;
   logic [CB-1:0] cnt_dec, cnt_inc;

   logic [CB+INIT_VALUE_W-1:0] init_ext, max_ext;

   logic [SAW-1:0] slot_base, slot_waddr, slot_raddr;
   logic           slot_we;
   logic [TW+TASK_ID_W-1:0]    task_ext;
   logic [TW-1:0]              slot_rd;
   logic [TW+WOKEN_TASK_W-1:0] woken_ext;
   logic [CB+COUNT_VALUE_W-1:0] count_ext;

   // Handshake.
   assign rsp_free       = !rsp_vld_ff || rsp_chan.ready;
   assign b_adv          = b_vld_ff && rsp_free;
   assign req_chan.ready = !b_vld_ff || rsp_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      b_vld_in = b_vld_ff;
      if (req_fire) begin
         b_vld_in = 1'b1;
      end else if (b_adv) begin
         b_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (b_adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Index decode.
   assign req_idx_ext = {{SIDX_W{1'b0}}, req_chan.sem_index};
   assign req_idx     = req_idx_ext[SIDX_W-1:0];
   assign b_idx_ext   = {{SIDX_W{1'b0}}, b_ff.sem_index};
   assign b_idx       = b_idx_ext[SIDX_W-1:0];
   assign b_in_range  = b_idx_ext < (SIDX_W+SEM_INDEX_W)'(NUM_SEMS);

   // A write of the same entry at the read edge is forwarded.
   assign fwd_hit_in = b_adv && st_we && (b_idx == req_idx);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_ff       <= '{mode: req_chan.mode, sem_index: req_chan.sem_index,
                         task_id: req_chan.task_id, init_value: req_chan.init_value};
         st_rd_ff   <= state_mem[req_idx];
         st_vld_ff  <= sem_vld_ff[req_idx];
         fwd_ff     <= st_new;
      end
      if (b_adv && st_we) begin
         state_mem[b_idx] <= st_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         sem_vld_ff <= '0;
      end else begin
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (req_fire) begin
            fwd_hit_ff <= fwd_hit_in;
         end
         if (b_adv && st_we) begin
            sem_vld_ff[b_idx] <= 1'b1;
         end
      end
   end

   // Operation logic.
   assign st_cur    = fwd_hit_ff ? fwd_ff : (st_vld_ff ? st_rd_ff : ST_RST);
   assign tail_next = next_ptr(st_cur.tail);
   assign cnt_dec   = CB'(st_cur.count - 1'b1);
   assign cnt_inc   = CB'(st_cur.count + 1'b1);
   assign init_ext  = {{CB{1'b0}}, b_ff.init_value};
   assign max_ext   = {{INIT_VALUE_W{1'b0}}, CNT_MAX};

   assign slot_base  = SAW'(SAW'(b_idx) * SAW'(QUEUE_DEPTH));
   assign slot_waddr = SAW'(slot_base + SAW'(tail_next));
   assign slot_raddr = SAW'(slot_base + SAW'(st_cur.head));

   always_comb begin
      st_new    = st_cur;
      st_we     = 1'b0;
      status_in = STAT_OK;
      wv_in     = 1'b0;
      slot_we   = 1'b0;
      if (!b_in_range) begin
         status_in = STAT_NOT_OPEN;
      end else begin
         case (mode_type'(b_ff.mode))
            MODE_OPEN: begin
               if (!st_cur.open) begin
                  st_new.open = 1'b1;
                  st_new.head = '0;
                  st_new.tail = TAIL_RST;
                  st_we       = 1'b1;
                  if (init_ext > max_ext) begin
                     st_new.count = CNT_MAX;
                     status_in    = STAT_OVERFLOW;
                  end else begin
                     st_new.count = init_ext[CB-1:0];
                  end
               end
            end
            MODE_WAIT: begin
               if (!st_cur.open) begin
                  status_in = STAT_NOT_OPEN;
               end else if (st_cur.count == CNT_MIN) begin
                  status_in = STAT_FULL;
               end else if (st_cur.count[CB-1] || (st_cur.count == '0)) begin
                  if (next_ptr(tail_next) == st_cur.head) begin
                     status_in = STAT_FULL;
                  end else begin
                     st_new.tail  = tail_next;
                     st_new.count = cnt_dec;
                     st_we        = 1'b1;
                     slot_we      = 1'b1;
                     status_in    = STAT_BLOCKED;
                  end
               end else begin
                  st_new.count = cnt_dec;
                  st_we        = 1'b1;
               end
            end
            MODE_POST: begin
               if (!st_cur.open) begin
                  status_in = STAT_NOT_OPEN;
               end else if (st_cur.count == CNT_MAX) begin
                  status_in = STAT_OVERFLOW;
               end else begin
                  st_new.count = cnt_inc;
                  st_we        = 1'b1;
                  if (st_cur.count[CB-1] && (tail_next != st_cur.head)) begin
                     wv_in       = 1'b1;
                     st_new.head = next_ptr(st_cur.head);
                  end
               end
            end
            MODE_READ: begin
               if (!st_cur.open) begin
                  status_in = STAT_NOT_OPEN;
               end
            end
            MODE_CLOSE: begin
               if (!st_cur.open) begin
                  status_in = STAT_NOT_OPEN;
               end else begin
                  st_new = ST_RST;
                  st_we  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      count_in = b_in_range ? st_new.count : '0;
   end

   assign task_ext = {{TW{1'b0}}, b_ff.task_id};

   semb_slot_ram #(
      .WIDTH (TW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (b_adv && slot_we),
      .wr_addr (slot_waddr),
      .wr_data (task_ext[TW-1:0]),
      .rd_en   (b_adv),
      .rd_addr (slot_raddr),
      .rd_data (slot_rd)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (b_adv) begin
         status_ff <= status_in;
         count_ff  <= count_in;
         wv_ff     <= wv_in;
      end
   end

   assign count_ext            = {{COUNT_VALUE_W{count_ff[CB-1]}}, count_ff};
   assign woken_ext            = {{WOKEN_TASK_W{1'b0}}, slot_rd};
   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.count_value = count_ext[COUNT_VALUE_W-1:0];
   assign rsp_chan.woken_valid = wv_ff;
   assign rsp_chan.woken_task  = wv_ff ? woken_ext[WOKEN_TASK_W-1:0] : '0;

   // A woken task comes only from a successful post that leaves the count at or below zero.
   a_woken_count: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && wv_ff |-> (status_ff == STAT_OK) && (count_ff[CB-1] || (count_ff == '0)))
      else $error("woken task with a positive count or an error status");

   // A blocked caller always leaves a negative count behind.
   a_blocked_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (status_ff == STAT_BLOCKED) |-> count_ff[CB-1])
      else $error("blocked caller with a non-negative count");

   // A closed or missing semaphore always reports a zero count.
   a_closed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (status_ff == STAT_NOT_OPEN) |-> (count_ff == '0))
      else $error("not-open status with a nonzero count");

   // The operation stage holds its word while the result side is blocked.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff && !rsp_free |=> b_vld_ff && $stable(b_ff))
      else $error("operation stage lost its word during a stall");

endmodule

`default_nettype wire
